@@ rtl/tagged_geometric_branch_predictor_macros.svh @@
// assertion macros for the tagged geometric branch predictor
// used by the top level only, no other dependencies
`ifndef TAGGED_GEOMETRIC_BRANCH_PREDICTOR_MACROS_SVH
`define TAGGED_GEOMETRIC_BRANCH_PREDICTOR_MACROS_SVH

// expression must never hold outside reset
`define TGBP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TGBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tgbp_pkg.sv @@
// shared constants and types for the tagged geometric branch predictor
// no dependencies
package tgbp_pkg;

    localparam int BASE_ENTRIES = 4096;
    localparam int BASE_AW      = $clog2(BASE_ENTRIES);
    localparam int TAG_ENTRIES  = 2048;
    localparam int TAG_AW       = $clog2(TAG_ENTRIES);
    localparam int NUM_TAGGED   = 4;
    localparam int CTR_W        = 4;
    localparam int TAG_W        = 8;
    localparam int U_W          = 2;
    localparam int HIST_W       = 128;
    localparam int PROV_W       = 3;
    localparam int CLR_ENTRIES  = (BASE_ENTRIES > TAG_ENTRIES) ? BASE_ENTRIES : TAG_ENTRIES;
    localparam int CLR_AW       = $clog2(CLR_ENTRIES);

    localparam logic [CTR_W-1:0] CTR_WEAK_NT = CTR_W'(7);
    localparam logic [CTR_W-1:0] CTR_MAX     = CTR_W'(15);
    localparam logic [U_W-1:0]   U_MAX       = U_W'(3);

    typedef struct packed {
        logic [CTR_W-1:0] ctr;
        logic [TAG_W-1:0] tag;
        logic [U_W-1:0]   u;
    } t_tent;

    localparam t_tent TENT_RESET = '{ctr: CTR_WEAK_NT, tag: '0, u: '0};

    // controller to datapath
    typedef struct packed {
        logic clr_we;
        logic rd_en;
        logic upd_en;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

@@ rtl/tgbp_ctrl.sv @@
// sequencer for the predictor: clearing sweep, lookup and update steps
// depends on tgbp_pkg
module tgbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  tgbp_pkg::t_sts i_sts,
    output tgbp_pkg::t_cmd o_cmd
);
    import tgbp_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} t_state;

    t_state r_state, n_state;
    logic   r_in_stall, r_out_valid;
    logic   n_out_valid;
    logic   w_upd;

    assign w_upd = (r_state == ST_UPDATE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_CLEAR:  if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_UPDATE;
            ST_UPDATE: if (w_upd) begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != ST_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.clr_we = (r_state == ST_CLEAR);
    assign o_cmd.rd_en  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.upd_en = w_upd;
    assign o_in_stall   = r_in_stall;
    assign o_out_valid  = r_out_valid;

endmodule

@@ rtl/tgbp_dp.sv @@
// predictor datapath: history, hashes, table memories, training logic
// depends on tgbp_pkg
module tgbp_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tgbp_pkg::t_cmd               i_cmd,
    output tgbp_pkg::t_sts               o_sts,
    input  logic [31:0]                  i_pc,
    input  logic                         i_taken,
    output logic                         o_pred_taken,
    output logic [tgbp_pkg::PROV_W-1:0]  o_provider_table
);
    import tgbp_pkg::*;

    function automatic logic [7:0] fold8(input logic [31:0] v);
        fold8 = v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
    endfunction

    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c, input logic up);
        if (up) ctr_train = (c == CTR_MAX) ? c : c + CTR_W'(1);
        else    ctr_train = (c == '0) ? c : c - CTR_W'(1);
    endfunction

    // memories
    logic [CTR_W-1:0] r_base_mem [BASE_ENTRIES];
    t_tent            r_tmem     [NUM_TAGGED][TAG_ENTRIES];

    logic [CLR_AW-1:0]  r_clr_addr;
    logic [HIST_W-1:0]  r_hist;
    logic [BASE_AW-1:0] r_idx0;
    logic [TAG_AW-1:0]  r_idx [NUM_TAGGED];
    logic [TAG_W-1:0]   r_tag [NUM_TAGGED];
    logic               r_taken;
    logic [CTR_W-1:0]   r_base_q;
    t_tent              r_tq  [NUM_TAGGED];
    logic               r_pred;
    logic [PROV_W-1:0]  r_prov;

    // lookup hashes from the incoming pc and the current history
    logic [31:0]       h1, h2, h3, h4;
    logic [7:0]        p8, f1, f2, f3;
    logic [10:0]       p11, g3;
    logic [TAG_AW-1:0] w_idx [NUM_TAGGED];
    logic [TAG_W-1:0]  w_tag [NUM_TAGGED];

    always_comb begin
        h1  = r_hist[31:0];
        h2  = r_hist[63:32];
        h3  = r_hist[95:64];
        h4  = r_hist[127:96];
        p8  = fold8(i_pc);
        p11 = i_pc[10:0] ^ i_pc[21:11] ^ {1'b0, i_pc[31:22]};
        f1  = fold8(h1);
        f2  = fold8(h2);
        f3  = fold8(h3);
        g3  = p11 ^ h1[10:0] ^ h1[21:11] ^ {1'b0, h1[31:22]} ^ {h2[0], 10'b0};
        w_tag[0] = p8 ^ {3'b0, h1[4:0]};
        w_tag[1] = p8 ^ h1[7:0] ^ {2'b0, h1[13:8]};
        w_tag[2] = p8 ^ f1 ^ {3'b0, h2[4:0]};
        w_tag[3] = p8 ^ f1 ^ f2 ^ f3 ^ {4'b0, h4[3:0]};
        w_idx[0] = p11 ^ {6'b0, h1[4:0]};
        w_idx[1] = p11 ^ h1[10:0] ^ {5'b0, h1[16:11]};
        w_idx[2] = g3 ^ {6'b0, h2[5:1]};
        w_idx[3] = g3 ^ h2[11:1] ^ h2[22:12] ^ {2'b0, h2[31:23]} ^ {h3[1:0], 9'b0}
                 ^ h3[12:2] ^ h3[23:13] ^ {3'b0, h3[31:24]} ^ {h4[2:0], 8'b0}
                 ^ {7'b0, h4[6:3]};
    end

    // provider, alternate and training
    logic              w_hit [NUM_TAGGED];
    logic [PROV_W-1:0] w_prov, w_alt, w_target;
    logic              w_found, w_pred, w_altp, w_mis;
    logic [CTR_W-1:0]  w_prov_ctr, w_alt_ctr;
    t_tent             w_wdata [NUM_TAGGED];
    logic              w_we    [NUM_TAGGED];

    always_comb begin
        w_prov   = '0;
        w_alt    = '0;
        w_found  = 1'b0;
        w_target = '0;
        for (int t = 0; t < NUM_TAGGED; t++) begin
            w_hit[t] = (r_tq[t].tag == r_tag[t]);
            if (w_hit[t]) w_prov = PROV_W'(t + 1);
        end
        for (int t = 0; t < NUM_TAGGED; t++) begin
            if (w_hit[t] && (PROV_W'(t + 1) < w_prov)) w_alt = PROV_W'(t + 1);
        end
        w_prov_ctr = (w_prov == '0) ? r_base_q : r_tq[2'(w_prov - PROV_W'(1))].ctr;
        w_alt_ctr  = (w_alt == '0) ? r_base_q : r_tq[2'(w_alt - PROV_W'(1))].ctr;
        w_pred     = w_prov_ctr > CTR_WEAK_NT;
        w_altp     = w_alt_ctr > CTR_WEAK_NT;
        w_mis      = (r_taken != w_pred);
        // first table above the provider with no usefulness left
        for (int t = 0; t < NUM_TAGGED; t++) begin
            if (!w_found && (PROV_W'(t + 1) > w_prov) && (r_tq[t].u == '0)) begin
                w_found  = 1'b1;
                w_target = PROV_W'(t + 1);
            end
        end
        for (int t = 0; t < NUM_TAGGED; t++) begin
            w_wdata[t] = r_tq[t];
            w_we[t]    = 1'b0;
            if (PROV_W'(t + 1) == w_prov) begin
                w_we[t] = 1'b1;
                if (w_pred != w_altp) begin
                    if (!w_mis) w_wdata[t].u = (r_tq[t].u == U_MAX) ? U_MAX : r_tq[t].u + U_W'(1);
                    else        w_wdata[t].u = (r_tq[t].u == '0) ? '0 : r_tq[t].u - U_W'(1);
                end
                w_wdata[t].ctr = ctr_train(r_tq[t].ctr, r_taken);
            end else if (w_mis && (PROV_W'(t + 1) > w_prov)) begin
                if (w_found) begin
                    if (PROV_W'(t + 1) == w_target) begin
                        w_we[t]        = 1'b1;
                        w_wdata[t].tag = r_tag[t];
                        w_wdata[t].ctr = CTR_WEAK_NT;
                    end
                end else begin
                    // aging, saturating at zero
                    w_we[t]      = 1'b1;
                    w_wdata[t].u = (r_tq[t].u == '0) ? '0 : r_tq[t].u - U_W'(1);
                end
            end
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            r_base_mem[r_clr_addr[BASE_AW-1:0]] <= CTR_WEAK_NT;
            for (int t = 0; t < NUM_TAGGED; t++) begin
                r_tmem[t][r_clr_addr[TAG_AW-1:0]] <= TENT_RESET;
            end
        end else if (i_cmd.upd_en) begin
            if (w_prov == '0) r_base_mem[r_idx0] <= ctr_train(r_base_q, r_taken);
            for (int t = 0; t < NUM_TAGGED; t++) begin
                if (w_we[t]) r_tmem[t][r_idx[t]] <= w_wdata[t];
            end
        end
        if (i_cmd.rd_en) begin
            r_base_q <= r_base_mem[i_pc[BASE_AW-1:0]];
            for (int t = 0; t < NUM_TAGGED; t++) begin
                r_tq[t] <= r_tmem[t][w_idx[t]];
            end
        end
    end

    // item registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_idx0  <= i_pc[BASE_AW-1:0];
            r_taken <= i_taken;
            for (int t = 0; t < NUM_TAGGED; t++) begin
                r_idx[t] <= w_idx[t];
                r_tag[t] <= w_tag[t];
            end
        end
        if (i_cmd.upd_en) begin
            r_pred <= w_pred;
            r_prov <= w_prov;
        end
    end

    // control state: sweep counter and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_hist     <= '0;
        end else begin
            if (i_cmd.clr_we) r_clr_addr <= r_clr_addr + CLR_AW'(1);
            if (i_cmd.upd_en) r_hist <= {r_hist[HIST_W-2:0], r_taken};
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == CLR_AW'(CLR_ENTRIES - 1));
    assign o_pred_taken     = r_pred;
    assign o_provider_table = r_prov;

endmodule

@@ rtl/tagged_geometric_branch_predictor.sv @@
// top level of the tagged geometric branch predictor
// depends on tgbp_pkg, tgbp_ctrl, tgbp_dp and the assertion macro header
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one resolved conditional
//   branch per beat: i_pc and i_taken.
//   output channel (o_out_valid / i_out_stall) returns one beat per branch:
//   o_pred_taken, the direction predicted before training, and
//   o_provider_table, 0 for the base table, 1 to 4 for a tagged table.
//   each branch passes a read step, which reads all five tables (the base
//   table at the low pc bits, the tagged ones at hashed indices), and then
//   an update step, which writes back counters, tags, usefulness and
//   history. the result appears in the output register on the cycle after
//   the update step. after reset the block sweeps all table entries back to
//   their initial values, one entry per cycle, with o_in_stall high.
//   while the receiver stalls, a waiting result holds and the block keeps
//   the next branch in its update step until the output register frees.
`include "tagged_geometric_branch_predictor_macros.svh"
module tagged_geometric_branch_predictor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [31:0]                  i_pc,
    input  logic                         i_taken,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_pred_taken,
    output logic [tgbp_pkg::PROV_W-1:0]  o_provider_table
);
    import tgbp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tgbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tgbp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_pc             (i_pc),
        .i_taken          (i_taken),
        .o_pred_taken     (o_pred_taken),
        .o_provider_table (o_provider_table)
    );

    `TGBP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "accepted beat did not make the block busy")
    `TGBP_ASSERT_NEVER(a_prov_range, i_clk, i_rst_n, o_out_valid && (o_provider_table > PROV_W'(4)), "provider table out of range")
    `TGBP_ASSERT_NEVER(a_clear_excl, i_clk, i_rst_n, w_cmd.clr_we && (w_cmd.upd_en || w_cmd.rd_en), "table access during clearing sweep")
    `TGBP_ASSERT_NEXT(a_result_after_upd, i_clk, i_rst_n, w_cmd.upd_en, o_out_valid, "update step gave no result")

endmodule
